// File: rtl/pulse_distance_sensor_decoder_core_macros.svh
// assertion macros for the pulse distance decoder
`ifndef PULSE_DISTANCE_SENSOR_DECODER_CORE_MACROS_SVH
`define PULSE_DISTANCE_SENSOR_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// consequent holds in the same cycle as the antecedent
`define PDSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdsd assertion failed");

// consequent holds in the cycle after the antecedent
`define PDSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdsd assertion failed");

`else

`define PDSD_ASSERT_NOW(label, ante, cons)
`define PDSD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/pdsd_pkg.sv
package pdsd_pkg;

  localparam int FRAME_PULSES_DEF = 82;
  localparam int INDEX_W          = 7;
  localparam int BITS_W           = 40;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 8;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LENGTH   = 3'd1;
  localparam logic [2:0] ST_MARK     = 3'd2;
  localparam logic [2:0] ST_GAP      = 3'd3;
  localparam logic [2:0] ST_HUMIDITY = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_MARK_MAX     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_GAP_MIN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_GAP_MAX = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_GAP_MIN  = 2'd3;

  localparam logic [7:0] MARK_MAX_RST     = 8'd21;
  localparam logic [7:0] ZERO_GAP_MIN_RST = 8'd46;
  localparam logic [7:0] ZERO_GAP_MAX_RST = 8'd78;
  localparam logic [7:0] ONE_GAP_MIN_RST  = 8'd93;

  // temperature: ((raw - 900 - 320) * 5) / 9
  localparam logic signed [15:0] TEMP_OFFSET5 = 16'sd6100;
  localparam logic [13:0]        RECIP_9      = 14'd14564;
  localparam int                 RECIP_SHIFT  = 17;
  localparam logic [15:0]        NEG_FLAG     = 16'h8000;
  localparam logic [7:0]         HUM_MAX      = 8'h99;

  typedef struct packed {
    logic [7:0] duration;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  device_id;
    logic [15:0] temperature_word;
    logic [7:0]  humidity_bcd;
  } out_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [BITS_W-1:0] bits;
  } frame_t;

endpackage

// File: rtl/pdsd_front.sv
module pdsd_front #(
  parameter int FRAME_PULSES = pdsd_pkg::FRAME_PULSES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pdsd_pkg::in_t                      in_word,
  input  logic                               cfg_we,
  input  logic [pdsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pdsd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               q_full,
  output logic                               push,
  output pdsd_pkg::frame_t                   push_word
);
  import pdsd_pkg::*;

  localparam logic [INDEX_W-1:0] FP    = INDEX_W'(FRAME_PULSES);
  localparam logic [INDEX_W-1:0] FP_M1 = INDEX_W'(FRAME_PULSES - 1);
  localparam logic [INDEX_W-1:0] FP_M2 = INDEX_W'(FRAME_PULSES - 2);

  logic [7:0]         mark_max;
  logic [7:0]         zero_gap_min;
  logic [7:0]         zero_gap_max;
  logic [7:0]         one_gap_min;
  logic [INDEX_W-1:0] pulse_index;
  logic [BITS_W-1:0]  bit_shift;
  logic [2:0]         first_error;

  logic [BITS_W-1:0]  bit_shift_next;
  logic [INDEX_W-1:0] pulse_index_next;
  logic [2:0]         item_err;
  logic [2:0]         first_error_next;
  logic [2:0]         final_err;
  logic               bit_val;
  logic               accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    item_err       = ST_OK;
    bit_val        = 1'b0;
    bit_shift_next = bit_shift;
    priority if (pulse_index >= FP) begin
      item_err = ST_LENGTH;
    end else if (pulse_index[0] && pulse_index <= FP_M2) begin
      if (in_word.duration > mark_max) item_err = ST_MARK;
    end else if (!pulse_index[0] && pulse_index >= INDEX_W'(2) && pulse_index <= FP_M1) begin
      bit_val = in_word.duration > one_gap_min;
      if (!bit_val && (in_word.duration < zero_gap_min || in_word.duration > zero_gap_max))
        item_err = ST_GAP;
      bit_shift_next = {bit_shift[BITS_W-2:0], bit_val};
    end else begin
      item_err = ST_OK;
    end
  end

  assign pulse_index_next = (pulse_index == INDEX_MAX) ? pulse_index
                                                       : pulse_index + INDEX_W'(1);
  assign first_error_next = (first_error != ST_OK) ? first_error : item_err;
  assign final_err = (first_error_next == ST_OK && pulse_index_next != FP) ? ST_LENGTH
                                                                           : first_error_next;

  assign push             = accept && in_word.last;
  assign push_word.status = final_err;
  assign push_word.bits   = bit_shift_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_max     <= MARK_MAX_RST;
      zero_gap_min <= ZERO_GAP_MIN_RST;
      zero_gap_max <= ZERO_GAP_MAX_RST;
      one_gap_min  <= ONE_GAP_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MARK_MAX:     mark_max     <= cfg_data;
        REG_ZERO_GAP_MIN: zero_gap_min <= cfg_data;
        REG_ZERO_GAP_MAX: zero_gap_max <= cfg_data;
        REG_ONE_GAP_MIN:  one_gap_min  <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_index <= '0;
      bit_shift   <= '0;
      first_error <= ST_OK;
    end else if (accept) begin
      if (in_word.last) begin
        pulse_index <= '0;
        bit_shift   <= '0;
        first_error <= ST_OK;
      end else begin
        pulse_index <= pulse_index_next;
        bit_shift   <= bit_shift_next;
        first_error <= first_error_next;
      end
    end
  end

endmodule

// File: rtl/pdsd_queue.sv
module pdsd_queue #(
  parameter int DEPTH = pdsd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pdsd_pkg::frame_t push_word,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output pdsd_pkg::frame_t q_word
);
  import pdsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign q_valid = count != '0;
  assign q_word  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

// File: rtl/pdsd_back.sv
module pdsd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pdsd_pkg::frame_t q_word,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output pdsd_pkg::out_t   out_word
);
  import pdsd_pkg::*;

  logic        a_valid;
  logic [2:0]  a_status;
  logic [7:0]  a_id;
  logic [7:0]  a_hum;
  logic        a_neg;
  logic [13:0] a_mag;

  logic        a_ready;
  logic        b_adv;
  logic [11:0] raw;
  logic [14:0] raw5;
  logic signed [15:0] t5;
  logic [15:0] t5_abs;
  logic [7:0]  hum;
  logic [2:0]  status_a;
  logic [27:0] prod;
  logic [10:0] quot;
  logic [15:0] temp_word;

  assign b_adv   = !out_valid || out_ready;
  assign a_ready = !a_valid || b_adv;
  assign pop     = q_valid && a_ready;

  // first stage: scaled offset temperature, magnitude and sign, humidity check
  assign raw    = q_word.bits[23:12];
  assign raw5   = {1'b0, raw, 2'b00} + {3'b000, raw};
  assign t5     = $signed({1'b0, raw5}) - TEMP_OFFSET5;
  assign t5_abs = t5[15] ? 16'(-t5) : 16'(t5);
  assign hum    = q_word.bits[11:4];
  assign status_a = (q_word.status == ST_OK && (hum == '0 || hum > HUM_MAX)) ? ST_HUMIDITY
                                                                            : q_word.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_status <= status_a;
      a_id     <= q_word.bits[39:32];
      a_hum    <= hum;
      a_neg    <= t5[15];
      a_mag    <= t5_abs[13:0];
    end
  end

  // second stage: divide by nine through the reciprocal, sign folding
  assign prod = 28'(a_mag) * 28'(RECIP_9);
  assign quot = prod[RECIP_SHIFT +: 11];
  assign temp_word = (a_neg && quot != '0) ? (NEG_FLAG | 16'(quot)) : 16'(quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid) begin
      out_word.status <= a_status;
      if (a_status == ST_OK) begin
        out_word.device_id        <= a_id;
        out_word.temperature_word <= temp_word;
        out_word.humidity_bcd     <= a_hum;
      end else begin
        out_word.device_id        <= '0;
        out_word.temperature_word <= '0;
        out_word.humidity_bcd     <= '0;
      end
    end
  end

endmodule

// File: rtl/pulse_distance_sensor_decoder_core.sv
// Decodes one 40-bit pulse-distance sensor frame from a stream of measured durations, one
// duration word per cycle while in_ready is high, with last set on the final one. The front
// end classifies each mark and gap against the four threshold registers and shifts in the
// bit in the same cycle, adding no stall; on the last word it hands a frame record to a
// two-entry queue. The back end turns the record into a result through two registers (offset
// and scale, then a reciprocal multiply for the divide by nine); out_ready can stall them.
// in_ready drops only while the queue holds two frames that the result side has not yet
// taken. Thresholds must be written only while idle; the block itself does not enforce it.
module pulse_distance_sensor_decoder_core #(
  parameter int FRAME_PULSES = pdsd_pkg::FRAME_PULSES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pdsd_pkg::in_t                    in_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pdsd_pkg::out_t                   out_word,
  input  logic                             cfg_we,
  input  logic [pdsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pdsd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pdsd_pkg::*;

`include "pulse_distance_sensor_decoder_core_macros.svh"

  logic   q_full;
  logic   push;
  frame_t push_word;
  logic   pop;
  logic   q_valid;
  frame_t q_word;

  pdsd_front #(
    .FRAME_PULSES (FRAME_PULSES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  pdsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_word    (q_word)
  );

  pdsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  `PDSD_ASSERT_NOW(a_failed_zero, out_valid && out_word.status != ST_OK, out_word.device_id == '0 && out_word.temperature_word == '0 && out_word.humidity_bcd == '0)
  `PDSD_ASSERT_NOW(a_no_neg_zero, out_valid, out_word.temperature_word != NEG_FLAG)
  `PDSD_ASSERT_NEXT(a_last_queued, in_valid && in_ready && in_word.last, q_valid)
  `PDSD_ASSERT_NOW(a_status_range, out_valid, out_word.status <= ST_HUMIDITY)

endmodule

// File: bench/pulse_distance_sensor_decoder_core_tb.sv
`timescale 1ns / 100ps

module pulse_distance_sensor_decoder_core_tb;
  import pdsd_pkg::*;

  localparam int FRAME_WORDS = FRAME_PULSES_DEF;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pulse_distance_sensor_decoder_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // threshold copies, tracked from the write port
  logic [7:0] mark_limit;
  logic [7:0] zero_lo;
  logic [7:0] zero_hi;
  logic [7:0] one_above;

  // frame decoder state
  logic [6:0] frame_pos;
  logic [39:0] frame_bits;
  logic [2:0] frame_err;

  in_t duration_queue[$];
  out_t expected_readings[$];

  logic in_taken = 1'b0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit hold_req = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int words_sent = 0;
  int frames_sent = 0;
  int settings_used = 1;
  int status_seen[5];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void flag_error(input logic [2:0] code);
    if (frame_err == ST_OK) frame_err = code;
  endfunction

  task automatic decode_duration(input in_t w);
    int p;
    int raw;
    int t;
    logic [7:0] hum;
    logic [15:0] tw;
    out_t r;
    p = frame_pos;
    if (p >= FRAME_WORDS) begin
      flag_error(ST_LENGTH);
    end else if (p % 2 == 1 && p <= FRAME_WORDS - 2) begin
      if (w.duration > mark_limit) flag_error(ST_MARK);
    end else if (p % 2 == 0 && p >= 2 && p <= FRAME_WORDS - 1) begin
      if (w.duration > one_above) begin
        frame_bits = {frame_bits[38:0], 1'b1};
      end else begin
        if (w.duration < zero_lo || w.duration > zero_hi) flag_error(ST_GAP);
        frame_bits = {frame_bits[38:0], 1'b0};
      end
    end
    frame_pos = (p >= int'(INDEX_MAX)) ? INDEX_MAX : 7'(p + 1);
    if (w.last) begin
      if (frame_pos != FRAME_WORDS) flag_error(ST_LENGTH);
      hum = frame_bits[11:4];
      raw = int'(frame_bits[23:12]);
      t = ((raw - 1220) * 5) / 9;
      tw = (t < 0) ? 16'(-t) + NEG_FLAG : 16'(t);
      if (hum == 8'h00 || hum > HUM_MAX) flag_error(ST_HUMIDITY);
      r = '0;
      r.status = frame_err;
      if (frame_err == ST_OK) begin
        r.device_id = frame_bits[39:32];
        r.temperature_word = tw;
        r.humidity_bcd = hum;
      end
      expected_readings.push_back(r);
      frame_pos = '0;
      frame_bits = '0;
      frame_err = ST_OK;
    end
  endtask

  task automatic note_mismatch(input string what, input out_t want, input out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected status %0d id %02h temp %04h hum %02h, got status %0d id %02h temp %04h hum %02h",
               what, want.status, want.device_id, want.temperature_word, want.humidity_bcd,
               got.status, got.device_id, got.temperature_word, got.humidity_bcd);
  endtask

  // monitor and predictor
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      in_taken <= 1'b0;
      mark_limit = MARK_MAX_RST;
      zero_lo = ZERO_GAP_MIN_RST;
      zero_hi = ZERO_GAP_MAX_RST;
      one_above = ONE_GAP_MIN_RST;
      frame_pos = '0;
      frame_bits = '0;
      frame_err = ST_OK;
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_we) begin
        case (cfg_index)
          REG_MARK_MAX: mark_limit = cfg_data;
          REG_ZERO_GAP_MIN: zero_lo = cfg_data;
          REG_ZERO_GAP_MAX: zero_hi = cfg_data;
          REG_ONE_GAP_MIN: one_above = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) decode_duration(in_word);
      if (out_valid && out_ready) begin
        if (out_word.status <= ST_HUMIDITY) status_seen[out_word.status]++;
        if (expected_readings.size() == 0) begin
          note_mismatch("unexpected result", '0, out_word);
        end else begin
          want = expected_readings.pop_front();
          if (out_word.status !== want.status || out_word.device_id !== want.device_id ||
              out_word.temperature_word !== want.temperature_word ||
              out_word.humidity_bcd !== want.humidity_bcd)
            note_mismatch("result mismatch", want, out_word);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("pulse_distance_sensor_decoder_core_tb failed");
        $finish;
      end
    end
  end

  // duration word driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if ($urandom_range(199, 0) == 0) tx_calm = !tx_calm;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (duration_queue.size() > 0) begin
        in_word <= duration_queue.pop_front();
        in_valid <= 1'b1;
        send_gap = tx_calm ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    logic ready_next;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(199, 0) == 0) rx_calm = !rx_calm;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        stall_left = rx_calm ? 0 : idle_len();
        ready_next = (stall_left == 0);
      end
      out_ready <= ready_next;
    end
  end

  task automatic queue_word(input logic [7:0] d, input logic l);
    in_t w;
    w.duration = d;
    w.last = l;
    duration_queue.push_back(w);
    words_sent++;
    if (l) frames_sent++;
  endtask

  function automatic logic [7:0] gap_for(input logic b);
    int lo;
    int hi;
    if (b && one_above != 8'hFF) return 8'($urandom_range(255, int'(one_above) + 1));
    lo = zero_lo;
    hi = (zero_hi < one_above) ? zero_hi : one_above;
    if (lo <= hi) return 8'($urandom_range(hi, lo));
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic logic [7:0] stray_gap();
    logic [7:0] v;
    for (int i = 0; i < 32; i++) begin
      v = 8'($urandom_range(255, 0));
      if (v <= one_above && (v < zero_lo || v > zero_hi)) return v;
    end
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic logic [39:0] reading_bits(input bit bad_hum);
    logic [11:0] raw;
    logic [7:0] hum;
    logic [3:0] tens;
    logic [3:0] ones;
    int r;
    r = $urandom_range(99, 0);
    if (r < 24) begin
      case (r % 6)
        0: raw = 12'd0;
        1: raw = 12'hFFF;
        2: raw = 12'd1220;
        3: raw = 12'd1219;
        4: raw = 12'd1218;
        default: raw = 12'd1229;
      endcase
    end else begin
      raw = 12'($urandom);
    end
    tens = 4'($urandom_range(9, 0));
    ones = (tens == 0) ? 4'($urandom_range(9, 1)) : 4'($urandom_range(9, 0));
    hum = {tens, ones};
    if (bad_hum) hum = ($urandom_range(2, 0) == 0) ? 8'h00 : 8'($urandom_range(255, 8'h9A));
    return {8'($urandom), 8'($urandom), raw, hum, 4'($urandom)};
  endfunction

  // bad_mark / bad_gap: word position of a deliberate fault, -1 for none
  task automatic send_frame(input logic [39:0] bits, input int n_words, input int bad_mark,
                            input int bad_gap);
    logic [7:0] d;
    for (int i = 0; i < n_words; i++) begin
      if (i == 0 || i >= FRAME_WORDS - 1)
        d = 8'($urandom);
      else if (i % 2 == 1)
        d = (i == bad_mark && mark_limit != 8'hFF) ?
            8'($urandom_range(255, int'(mark_limit) + 1)) : 8'($urandom_range(mark_limit, 0));
      else
        d = (i == bad_gap) ? stray_gap() : gap_for(bits[40 - i / 2]);
      queue_word(d, i == n_words - 1);
    end
  endtask

  task automatic random_frame();
    int r;
    int n;
    logic [39:0] bits;
    r = $urandom_range(99, 0);
    bits = reading_bits(r >= 82 && r < 88);
    if (r < 55) begin
      send_frame(bits, FRAME_WORDS, -1, -1);
    end else if (r < 63) begin
      send_frame(bits, FRAME_WORDS, 2 * $urandom_range(39, 0) + 1, -1);
    end else if (r < 71) begin
      send_frame(bits, FRAME_WORDS, -1, 2 * $urandom_range(40, 1));
    end else if (r < 74) begin
      send_frame(bits, FRAME_WORDS, 2 * $urandom_range(39, 0) + 1, 2 * $urandom_range(40, 1));
    end else if (r < 78) begin
      send_frame(bits, $urandom_range(FRAME_WORDS - 1, 1), -1, -1);
    end else if (r < 82) begin
      send_frame(bits, $urandom_range(140, FRAME_WORDS + 1), -1, -1);
    end else if (r < 88) begin
      send_frame(bits, FRAME_WORDS, -1, -1);
    end else begin
      n = $urandom_range(24, 1);
      for (int i = 0; i < n; i++) queue_word(8'($urandom), i == n - 1);
    end
  endtask

  task automatic wait_idle();
    while (!(duration_queue.size() == 0 && !in_valid && expected_readings.size() == 0))
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [7:0] m, input logic [7:0] zl, input logic [7:0] zh,
                                input logic [7:0] o);
    wait_idle();
    write_reg(REG_MARK_MAX, m);
    write_reg(REG_ZERO_GAP_MIN, zl);
    write_reg(REG_ZERO_GAP_MAX, zh);
    write_reg(REG_ONE_GAP_MIN, o);
    @(posedge clk);
    settings_used++;
  endtask

  task automatic random_phase(input int budget, input int min_frames);
    int w0;
    int f0;
    w0 = words_sent;
    f0 = frames_sent;
    while (words_sent - w0 < budget || frames_sent - f0 < min_frames) random_frame();
  endtask

  initial begin
    int zl;
    int zh;
    int spin;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames at reset thresholds
    queue_word(8'h00, 1'b1);
    queue_word(8'hFF, 1'b1);
    send_frame({8'h00, 8'h00, 12'h000, 8'h01, 4'h0}, FRAME_WORDS, -1, -1);
    send_frame({8'hFF, 8'hFF, 12'hFFF, 8'h99, 4'hF}, FRAME_WORDS, -1, -1);
    send_frame({8'hA5, 8'h3C, 12'd1219, 8'h45, 4'h6}, FRAME_WORDS, -1, -1);
    send_frame({8'h5A, 8'hC3, 12'd1218, 8'h50, 4'h9}, FRAME_WORDS, -1, -1);
    send_frame({8'h12, 8'h00, 12'd1500, 8'h00, 4'h0}, FRAME_WORDS, -1, -1);
    send_frame({8'h34, 8'h00, 12'd1500, 8'h9A, 4'h0}, FRAME_WORDS, -1, -1);
    send_frame({8'h56, 8'h00, 12'd1400, 8'h33, 4'h0}, FRAME_WORDS, 3, 40);
    send_frame({8'h78, 8'h00, 12'd1400, 8'h33, 4'h0}, FRAME_WORDS, 79, 4);
    send_frame({8'h9A, 8'h00, 12'd1400, 8'hFF, 4'h0}, FRAME_WORDS, -1, 60);
    send_frame({8'hBC, 8'h00, 12'd1400, 8'h33, 4'h0}, FRAME_WORDS - 1, -1, -1);
    send_frame({8'hDE, 8'h00, 12'd1400, 8'h33, 4'h0}, 130, -1, -1);

    set_thresholds(8'd0, 8'd0, 8'd0, 8'd0);
    random_phase(60, 1);
    set_thresholds(8'd255, 8'd255, 8'd255, 8'd255);
    random_phase(60, 1);
    zl = $urandom_range(80, 0);
    zh = zl + $urandom_range(60, 0);
    set_thresholds(8'($urandom_range(60, 10)), 8'(zl), 8'(zh),
                   8'((zh + $urandom_range(60, 0) > 255) ? 255 : zh + $urandom_range(60, 0)));
    random_phase(60, 1);
    set_thresholds(8'd255, 8'd0, 8'd255, 8'd0);
    random_phase(60, 1);

    // output held off while short frames pile up behind it
    set_thresholds(MARK_MAX_RST, ZERO_GAP_MIN_RST, ZERO_GAP_MAX_RST, ONE_GAP_MIN_RST);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) queue_word(8'($urandom), 1'b1);
    random_phase(60, 1);

    set_thresholds(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(60, 1);

    while (!(duration_queue.size() == 0 && !in_valid)) @(posedge clk);
    for (spin = 0; spin < 20000 && expected_readings.size() != 0; spin++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_readings.size() != 0) begin
      mismatches += expected_readings.size();
      $display("%0d expected results never arrived", expected_readings.size());
    end

    $display("covered %0d duration words in %0d frames over %0d threshold settings, %0d long hold",
             words_sent, frames_sent, settings_used, holds_done);
    $display("results by status: ok %0d, length %0d, mark %0d, gap %0d, humidity %0d; mismatches %0d",
             status_seen[ST_OK], status_seen[ST_LENGTH], status_seen[ST_MARK], status_seen[ST_GAP],
             status_seen[ST_HUMIDITY], mismatches);
    if (mismatches == 0) begin
      $display("pulse_distance_sensor_decoder_core_tb passed");
    end else begin
      $display("pulse_distance_sensor_decoder_core_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pdsd_pkg.sv
rtl/pdsd_front.sv
rtl/pdsd_queue.sv
rtl/pdsd_back.sv
rtl/pulse_distance_sensor_decoder_core.sv
bench/pulse_distance_sensor_decoder_core_tb.sv
